FILE: rtl/core/lerp_pkg.sv
// Shared types and constants of the lottery/EDF/round-robin picker.
// Used by the top level and the shared ALU; depends on nothing.
`default_nettype none
package lerp_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ALU_W = 32;
  localparam int SLOT_W = 4;
  localparam int TICKET_W = 8;
  localparam int DEADLINE_W = 31;
  localparam int DRAW_W = 31;
  localparam int LIMIT_W = 4;

  localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST = 4'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READY = 2'd2;
  localparam logic [1:0] OP_SELECT = 2'd3;

  localparam logic [1:0] CLS_RR = 2'd0;
  localparam logic [1:0] CLS_LOTTERY = 2'd1;
  localparam logic [1:0] CLS_REALTIME = 2'd2;

  localparam logic CFG_LOT_LIMIT = 1'b0;
  localparam logic CFG_RT_LIMIT = 1'b1;

  // Per-slot descriptor held in the info memory.
  typedef struct packed {
    logic [1:0]            cls;
    logic [TICKET_W-1:0]   tickets;
    logic [DEADLINE_W-1:0] deadline;
  } info_t;

endpackage
`default_nettype wire

FILE: rtl/core/lottery_edf_round_robin_picker.sv
// Top level of the thread-slot picker: sequencer, slot tables and ring links.
// Depends on lerp_pkg, lerp_ram and lerp_alu.
//
// The block accepts one item at a time. An add that is taken and finds the ring
// non-empty links the new slot behind the tail in an extra step; set ready
// writes its flag directly. A remove walks from the ring head to the removed
// slot. The ring links sit in a memory with a registered read, so each step
// along the ring spends one phase waiting for the read and one using it. A
// select walks the ring at most three times, and every arithmetic step uses
// one shared add/subtract unit. Unless the lottery has reached its turn limit,
// the lottery ticket sum comes first. It is followed either by a remainder of
// the random draw by the ticket total and the lottery pick, or by the
// earliest-deadline scan and the round-robin scan. The result goes to an
// output register, so a new item can be taken while a result is still waiting
// on the result channel. Configuration writes are taken in every cycle.
`default_nettype none
module lottery_edf_round_robin_picker #(
  parameter int SLOTS = lerp_pkg::SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_op,
  input  wire logic [lerp_pkg::SLOT_W-1:0]         in_slot,
  input  wire logic [1:0]                          in_sched_class,
  input  wire logic [lerp_pkg::TICKET_W-1:0]       in_ticket_count,
  input  wire logic [lerp_pkg::DEADLINE_W-1:0]     in_deadline,
  input  wire logic                                in_ready_req,
  input  wire logic                                in_current_valid,
  input  wire logic [lerp_pkg::SLOT_W-1:0]         in_current_slot,
  input  wire logic [lerp_pkg::DRAW_W-1:0]         in_random_draw,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic      [lerp_pkg::SLOT_W-1:0]         out_chosen_slot,
  output logic      [1:0]                          out_chosen_policy,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [lerp_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int TOT_W = lerp_pkg::TICKET_W + IDX_W;
  localparam int INFO_W = $bits(lerp_pkg::info_t);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(SLOTS - 1);
  localparam logic [4:0] MOD_LAST = 5'(lerp_pkg::DRAW_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ADD2, S_REM_WALK, S_LOT_SUM, S_LOT_MOD, S_LOT_PICK,
    S_RT_START, S_RT_WALK, S_RR_START, S_RR_CUR, S_RR_WALK, S_FIN
  } state_t;

  state_t state_r;

  // Latched item.
  logic [1:0]                      op_r;
  logic [lerp_pkg::SLOT_W-1:0]     slot_r;
  logic [1:0]                      cls_r;
  logic [lerp_pkg::TICKET_W-1:0]   tickets_r;
  logic [lerp_pkg::DEADLINE_W-1:0] deadline_r;
  logic                            rdy_r;
  logic                            cvalid_r;
  logic [lerp_pkg::SLOT_W-1:0]     cslot_r;
  logic [lerp_pkg::DRAW_W-1:0]     dsh_r;

  // Scheduler state.
  logic [SLOTS-1:0]       used_r;
  logic [IDX_W-1:0]       head_r;
  logic [IDX_W-1:0]       tail_r;
  logic                   nonempty_r;
  logic [lerp_pkg::LIMIT_W-1:0] lot_turns_r;
  logic [lerp_pkg::LIMIT_W-1:0] rt_turns_r;
  logic [lerp_pkg::LIMIT_W-1:0] lot_lim_r;
  logic [lerp_pkg::LIMIT_W-1:0] rt_lim_r;

  // Walk state.
  logic [IDX_W-1:0]       ptr_r;
  logic                   ph_r;
  logic [IDX_W-1:0]       i_r;
  logic [IDX_W-1:0]       prev_r;
  logic [IDX_W-1:0]       start_r;
  logic                   cur_ok_r;
  logic [TOT_W-1:0]       tot_r;
  logic [TOT_W-1:0]       rem_r;
  logic [4:0]             k_r;
  logic                   have_r;
  logic [IDX_W-1:0]       best_r;
  logic [lerp_pkg::DEADLINE_W-1:0] best_dl_r;

  // Pending result.
  logic                   res_found_r;
  logic [IDX_W-1:0]       res_slot_r;
  logic [1:0]             res_pol_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [lerp_pkg::SLOT_W-1:0] out_slot_r;
  logic [1:0]             out_pol_r;

  // Memories.
  logic                   info_we;
  logic [IDX_W-1:0]       info_waddr;
  lerp_pkg::info_t        info_wdata;
  logic [INFO_W-1:0]      info_rdata;
  lerp_pkg::info_t        info_q;
  logic                   rdy_we;
  logic [IDX_W-1:0]       rdy_waddr;
  logic                   rdy_wdata;
  logic                   ready_q;
  logic                   link_we;
  logic [IDX_W-1:0]       link_waddr;
  logic [IDX_W-1:0]       link_wdata;
  logic [IDX_W-1:0]       link_q;

  // ALU.
  logic [lerp_pkg::ALU_W-1:0] alu_a;
  logic [lerp_pkg::ALU_W-1:0] alu_b;
  logic                       alu_sub;
  logic [lerp_pkg::ALU_W-1:0] alu_res;
  logic                       alu_borrow;

  logic                   slot_ok;
  logic [IDX_W-1:0]       slot_idx;
  logic                   cur_ok;
  logic                   elig_lot;
  logic                   elig_rt;
  logic                   elig_rr;
  logic [IDX_W-1:0]       walk_stop;
  logic                   walk_last;
  logic [TOT_W-1:0]       tot_nxt;
  logic [TOT_W:0]         trial;
  logic                   rt_take;

  lerp_ram #(.W(INFO_W), .DEPTH(SLOTS)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(ptr_r), .rdata(info_rdata)
  );

  lerp_ram #(.W(1), .DEPTH(SLOTS)) u_ready_ram (
    .clk(clk), .we(rdy_we), .waddr(rdy_waddr), .wdata(rdy_wdata),
    .raddr(ptr_r), .rdata(ready_q)
  );

  lerp_ram #(.W(IDX_W), .DEPTH(SLOTS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(ptr_r), .rdata(link_q)
  );

  lerp_alu u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .borrow(alu_borrow)
  );

  assign info_q = lerp_pkg::info_t'(info_rdata);

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_chosen_slot = out_slot_r;
  assign out_chosen_policy = out_pol_r;

  always_comb begin
    slot_ok = ({{(32 - lerp_pkg::SLOT_W){1'b0}}, slot_r} < 32'(SLOTS));
    slot_idx = IDX_W'(slot_r);
    cur_ok = cvalid_r && ({{(32 - lerp_pkg::SLOT_W){1'b0}}, cslot_r} < 32'(SLOTS))
             && used_r[IDX_W'(cslot_r)];
    elig_lot = ready_q && (info_q.cls == lerp_pkg::CLS_LOTTERY);
    elig_rt = ready_q && (info_q.cls == lerp_pkg::CLS_REALTIME);
    elig_rr = ready_q && (info_q.cls == lerp_pkg::CLS_RR);
    walk_stop = (state_r == S_RR_WALK) ? start_r : head_r;
    walk_last = (link_q == walk_stop) || (i_r == LAST_I);
    trial = {rem_r, dsh_r[lerp_pkg::DRAW_W-1]};
  end

  // The one shared add/subtract unit, steered by the sequencer.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_LOT_SUM: begin
        alu_a = lerp_pkg::ALU_W'(tot_r);
        alu_b = lerp_pkg::ALU_W'(info_q.tickets);
      end
      S_LOT_MOD: begin
        alu_a = lerp_pkg::ALU_W'(trial);
        alu_b = lerp_pkg::ALU_W'(tot_r);
        alu_sub = 1'b1;
      end
      S_LOT_PICK: begin
        alu_a = lerp_pkg::ALU_W'(rem_r);
        alu_b = lerp_pkg::ALU_W'(info_q.tickets);
        alu_sub = 1'b1;
      end
      S_RT_WALK: begin
        alu_a = lerp_pkg::ALU_W'(info_q.deadline);
        alu_b = lerp_pkg::ALU_W'(best_dl_r);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
    tot_nxt = elig_lot ? TOT_W'(alu_res) : tot_r;
    rt_take = elig_rt && (!have_r || alu_borrow);
  end

  // Memory writes: only one of the cases can be active in any cycle.
  always_comb begin
    info_we = 1'b0;
    info_waddr = slot_idx;
    info_wdata = '{cls: cls_r, tickets: tickets_r, deadline: deadline_r};
    rdy_we = 1'b0;
    rdy_waddr = slot_idx;
    rdy_wdata = 1'b1;
    link_we = 1'b0;
    link_waddr = slot_idx;
    link_wdata = nonempty_r ? head_r : slot_idx;
    case (state_r)
      S_EXEC: begin
        if (op_r == lerp_pkg::OP_ADD && slot_ok && !used_r[slot_idx]) begin
          info_we = 1'b1;
          rdy_we = 1'b1;
          link_we = 1'b1;
        end
        if (op_r == lerp_pkg::OP_READY && slot_ok && used_r[slot_idx]) begin
          rdy_we = 1'b1;
          rdy_wdata = rdy_r;
        end
      end
      S_ADD2: begin
        link_we = 1'b1;
        link_waddr = tail_r;
        link_wdata = slot_idx;
      end
      S_REM_WALK: begin
        if (ph_r && ptr_r == slot_idx && link_q != ptr_r) begin
          link_we = 1'b1;
          link_waddr = prev_r;
          link_wdata = link_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      nonempty_r <= 1'b0;
      lot_turns_r <= '0;
      rt_turns_r <= '0;
      lot_lim_r <= lerp_pkg::TURN_LIMIT_RST;
      rt_lim_r <= lerp_pkg::TURN_LIMIT_RST;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lerp_pkg::CFG_LOT_LIMIT) begin
          lot_lim_r <= cfg_data;
        end else begin
          rt_lim_r <= cfg_data;
        end
      end

      // The finishing state loads the output register itself.
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_op;
            slot_r <= in_slot;
            cls_r <= in_sched_class;
            tickets_r <= in_ticket_count;
            deadline_r <= in_deadline;
            rdy_r <= in_ready_req;
            cvalid_r <= in_current_valid;
            cslot_r <= in_current_slot;
            dsh_r <= in_random_draw;
            res_found_r <= 1'b0;
            res_slot_r <= '0;
            res_pol_r <= lerp_pkg::CLS_RR;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          ph_r <= 1'b0;
          i_r <= '0;
          unique case (op_r)
            lerp_pkg::OP_ADD: begin
              if (slot_ok && !used_r[slot_idx]) begin
                used_r[slot_idx] <= 1'b1;
                res_found_r <= 1'b1;
                if (nonempty_r) begin
                  state_r <= S_ADD2;
                end else begin
                  head_r <= slot_idx;
                  tail_r <= slot_idx;
                  nonempty_r <= 1'b1;
                  state_r <= S_FIN;
                end
              end else begin
                state_r <= S_FIN;
              end
            end
            lerp_pkg::OP_REMOVE: begin
              if (slot_ok && used_r[slot_idx]) begin
                used_r[slot_idx] <= 1'b0;
                res_found_r <= 1'b1;
                ptr_r <= head_r;
                prev_r <= tail_r;
                state_r <= S_REM_WALK;
              end else begin
                state_r <= S_FIN;
              end
            end
            lerp_pkg::OP_READY: begin
              res_found_r <= slot_ok && used_r[slot_idx];
              state_r <= S_FIN;
            end
            lerp_pkg::OP_SELECT: begin
              cur_ok_r <= cur_ok;
              // Lottery gives up one turn once it has reached its limit.
              if (lot_turns_r >= lot_lim_r) begin
                lot_turns_r <= '0;
                state_r <= S_RT_START;
              end else if (!nonempty_r) begin
                state_r <= S_RT_START;
              end else begin
                ptr_r <= head_r;
                tot_r <= '0;
                state_r <= S_LOT_SUM;
              end
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end

        S_ADD2: begin
          tail_r <= slot_idx;
          state_r <= S_FIN;
        end

        S_REM_WALK: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            i_r <= i_r + 1'b1;
            if (ptr_r == slot_idx) begin
              if (link_q == ptr_r) begin
                head_r <= '0;
                tail_r <= '0;
                nonempty_r <= 1'b0;
              end else begin
                if (ptr_r == head_r) begin
                  head_r <= link_q;
                end
                if (ptr_r == tail_r) begin
                  tail_r <= prev_r;
                end
              end
              state_r <= S_FIN;
            end else begin
              prev_r <= ptr_r;
              ptr_r <= link_q;
              if (walk_last) begin
                state_r <= S_FIN;
              end
            end
          end
        end

        S_LOT_SUM: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            tot_r <= tot_nxt;
            ptr_r <= link_q;
            i_r <= i_r + 1'b1;
            if (walk_last) begin
              if (tot_nxt == '0) begin
                state_r <= S_RT_START;
              end else begin
                rem_r <= '0;
                k_r <= '0;
                state_r <= S_LOT_MOD;
              end
            end
          end
        end

        // Restoring remainder: one bit of the draw per cycle.
        S_LOT_MOD: begin
          rem_r <= alu_borrow ? TOT_W'(trial) : TOT_W'(alu_res);
          dsh_r <= {dsh_r[lerp_pkg::DRAW_W-2:0], 1'b0};
          k_r <= k_r + 1'b1;
          if (k_r == MOD_LAST) begin
            ptr_r <= head_r;
            ph_r <= 1'b0;
            i_r <= '0;
            state_r <= S_LOT_PICK;
          end
        end

        S_LOT_PICK: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (elig_lot && alu_borrow) begin
              lot_turns_r <= lot_turns_r + 1'b1;
              res_found_r <= 1'b1;
              res_slot_r <= ptr_r;
              res_pol_r <= lerp_pkg::CLS_LOTTERY;
              state_r <= S_FIN;
            end else begin
              if (elig_lot) begin
                rem_r <= TOT_W'(alu_res);
              end
              ptr_r <= link_q;
              i_r <= i_r + 1'b1;
              if (walk_last) begin
                state_r <= S_RT_START;
              end
            end
          end
        end

        S_RT_START: begin
          ph_r <= 1'b0;
          i_r <= '0;
          have_r <= 1'b0;
          if (rt_turns_r >= rt_lim_r) begin
            rt_turns_r <= '0;
            state_r <= S_RR_START;
          end else if (!nonempty_r) begin
            state_r <= S_RR_START;
          end else begin
            ptr_r <= head_r;
            state_r <= S_RT_WALK;
          end
        end

        // Earliest deadline; a strict compare keeps the first slot on ties.
        S_RT_WALK: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (rt_take) begin
              have_r <= 1'b1;
              best_r <= ptr_r;
              best_dl_r <= info_q.deadline;
            end
            ptr_r <= link_q;
            i_r <= i_r + 1'b1;
            if (walk_last) begin
              if (have_r || rt_take) begin
                rt_turns_r <= rt_turns_r + 1'b1;
                res_found_r <= 1'b1;
                res_slot_r <= rt_take ? ptr_r : best_r;
                res_pol_r <= lerp_pkg::CLS_REALTIME;
                state_r <= S_FIN;
              end else begin
                state_r <= S_RR_START;
              end
            end
          end
        end

        S_RR_START: begin
          ph_r <= 1'b0;
          i_r <= '0;
          if (!nonempty_r) begin
            state_r <= S_FIN;
          end else if (cur_ok_r) begin
            ptr_r <= IDX_W'(cslot_r);
            start_r <= IDX_W'(cslot_r);
            state_r <= S_RR_CUR;
          end else begin
            ptr_r <= head_r;
            start_r <= head_r;
            state_r <= S_RR_WALK;
          end
        end

        // Fetch the link of the current slot so the scan starts after it.
        S_RR_CUR: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            ptr_r <= link_q;
            state_r <= S_RR_WALK;
          end
        end

        S_RR_WALK: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (elig_rr) begin
              res_found_r <= 1'b1;
              res_slot_r <= ptr_r;
              res_pol_r <= lerp_pkg::CLS_RR;
              state_r <= S_FIN;
            end else begin
              ptr_r <= link_q;
              i_r <= i_r + 1'b1;
              if (walk_last) begin
                state_r <= S_FIN;
              end
            end
          end
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_slot_r <= lerp_pkg::SLOT_W'(res_slot_r);
            out_pol_r <= res_pol_r;
            state_r <= S_IDLE;
          end else begin
            out_valid_r <= 1'b1;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lerp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module lerp_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/lerp_alu.sv
// Shared add/subtract unit with a borrow flag used by the lottery and deadline steps.
// Depends on lerp_pkg for the datapath width.
`default_nettype none
module lerp_alu (
  input  wire logic [lerp_pkg::ALU_W-1:0] a,
  input  wire logic [lerp_pkg::ALU_W-1:0] b,
  input  wire logic                       sub,
  output logic      [lerp_pkg::ALU_W-1:0] res,
  output logic                            borrow
);

  logic [lerp_pkg::ALU_W:0] sum;

  // A subtract is a plus the inverted b plus one; no carry out means a < b.
  always_comb begin
    sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{lerp_pkg::ALU_W{1'b0}}, sub};
    res = sum[lerp_pkg::ALU_W-1:0];
    borrow = sub & ~sum[lerp_pkg::ALU_W];
  end

endmodule
`default_nettype wire

FILE: dv/lottery_edf_round_robin_picker_tb.sv
// Self-checking testbench of the lottery/EDF/round-robin thread-slot picker.
// Drives ring operations and selects, predicts every result in-bench and
// compares it field by field; depends on lerp_pkg and the picker RTL.
`default_nettype none
module lottery_edf_round_robin_picker_tb;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  // One operation presented on the input channel.
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [1:0]  cls;
    logic [7:0]  tickets;
    logic [30:0] deadline;
    logic        ready_req;
    logic        cur_valid;
    logic [3:0]  cur_slot;
    logic [30:0] draw;
  } sched_op_t;

  // One decision or acknowledgement coming back on the result channel.
  typedef struct {
    logic       found;
    logic [3:0] slot;
    logic [1:0] policy;
  } decision_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [3:0]  in_slot;
  logic [1:0]  in_sched_class;
  logic [7:0]  in_ticket_count;
  logic [30:0] in_deadline;
  logic        in_ready_req;
  logic        in_current_valid;
  logic [3:0]  in_current_slot;
  logic [30:0] in_random_draw;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic [3:0]  out_chosen_slot;
  logic [1:0]  out_chosen_policy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [3:0]  cfg_data;

  lottery_edf_round_robin_picker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_sched_class    (in_sched_class),
    .in_ticket_count   (in_ticket_count),
    .in_deadline       (in_deadline),
    .in_ready_req      (in_ready_req),
    .in_current_valid  (in_current_valid),
    .in_current_slot   (in_current_slot),
    .in_random_draw    (in_random_draw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_chosen_slot   (out_chosen_slot),
    .out_chosen_policy (out_chosen_policy),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pending operations for the driver and decisions still owed by the block.
  sched_op_t pending_ops[$];
  decision_t owed_decisions[$];

  // Percentage of cycles in which the sender holds back or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;

  // In-bench copy of the picker state, updated as each item is accepted.
  bit         slot_busy[NSLOT];
  bit         slot_rdy[NSLOT];
  logic [1:0] slot_cls[NSLOT];
  logic [7:0] slot_tix[NSLOT];
  logic [30:0] slot_dl[NSLOT];
  logic [3:0] ring_next[NSLOT];
  logic [3:0] ring_head;
  logic [3:0] ring_tail;
  bit         ring_live;
  logic [3:0] lot_run;
  logic [3:0] rt_run;
  logic [3:0] lot_cap;
  logic [3:0] rt_cap;

  function automatic bit runnable(input logic [3:0] s, input logic [1:0] c);
    return slot_rdy[s] && slot_cls[s] == c;
  endfunction

  // Lottery: sum the tickets of ready lottery slots, reduce the draw by that
  // total and walk the ring again until the draw falls inside a slot's share.
  function automatic bit lottery_pick(input logic [30:0] draw, output logic [3:0] who);
    int unsigned total;
    int unsigned d;
    logic [3:0]  s;
    who = '0;
    if (lot_run >= lot_cap) begin
      lot_run = '0;
      return 1'b0;
    end
    if (!ring_live) return 1'b0;
    total = 0;
    s = ring_head;
    for (int i = 0; i < NSLOT; i++) begin
      if (runnable(s, lerp_pkg::CLS_LOTTERY)) total += slot_tix[s];
      s = ring_next[s];
      if (s == ring_head) break;
    end
    if (total == 0) return 1'b0;
    d = draw % total;
    s = ring_head;
    for (int i = 0; i < NSLOT; i++) begin
      if (runnable(s, lerp_pkg::CLS_LOTTERY)) begin
        if (d < slot_tix[s]) begin
          lot_run = lot_run + 4'd1;
          who = s;
          return 1'b1;
        end
        d -= slot_tix[s];
      end
      s = ring_next[s];
      if (s == ring_head) break;
    end
    return 1'b0;
  endfunction

  // Earliest deadline among ready realtime slots; ties go to the first in ring order.
  function automatic bit deadline_pick(output logic [3:0] who);
    logic [3:0] s;
    logic [3:0] best;
    bit         have;
    who = '0;
    best = '0;
    have = 1'b0;
    if (rt_run >= rt_cap) begin
      rt_run = '0;
      return 1'b0;
    end
    if (!ring_live) return 1'b0;
    s = ring_head;
    for (int i = 0; i < NSLOT; i++) begin
      if (runnable(s, lerp_pkg::CLS_REALTIME) &&
          (!have || slot_dl[s] < slot_dl[best])) begin
        best = s;
        have = 1'b1;
      end
      s = ring_next[s];
      if (s == ring_head) break;
    end
    if (have) begin
      rt_run = rt_run + 4'd1;
      who = best;
    end
    return have;
  endfunction

  // Round robin starts after the running slot and rechecks it only when it is the only slot.
  function automatic bit rotation_pick(input bit cur_ok, input logic [3:0] cur,
                                       output logic [3:0] who);
    logic [3:0] first;
    logic [3:0] s;
    who = '0;
    if (!ring_live) return 1'b0;
    first = cur_ok ? cur : ring_head;
    s = cur_ok ? ring_next[cur] : ring_head;
    for (int i = 0; i < NSLOT; i++) begin
      if (runnable(s, lerp_pkg::CLS_RR)) begin
        who = s;
        return 1'b1;
      end
      s = ring_next[s];
      if (s == first) break;
    end
    return 1'b0;
  endfunction

  function automatic void ring_unlink(input logic [3:0] t);
    logic [3:0] prev;
    logic [3:0] cur;
    prev = ring_tail;
    cur = ring_head;
    for (int i = 0; i < NSLOT; i++) begin
      if (cur == t) begin
        if (cur == ring_head) ring_head = ring_next[cur];
        if (cur == ring_tail) ring_tail = prev;
        if (ring_next[cur] == cur) begin
          ring_head = '0;
          ring_tail = '0;
          ring_live = 1'b0;
        end else begin
          ring_next[prev] = ring_next[cur];
        end
        return;
      end
      prev = cur;
      cur = ring_next[cur];
      if (cur == ring_head) return;
    end
  endfunction

  // Applies one accepted operation to the in-bench state and returns its decision.
  function automatic decision_t apply_op(input sched_op_t x);
    decision_t  r;
    logic [3:0] who;
    bit         cur_ok;
    r.found = 1'b0;
    r.slot = '0;
    r.policy = lerp_pkg::CLS_RR;
    case (x.op)
      lerp_pkg::OP_ADD: begin
        if (!slot_busy[x.slot]) begin
          slot_busy[x.slot] = 1'b1;
          slot_rdy[x.slot] = 1'b1;
          slot_cls[x.slot] = x.cls;
          slot_tix[x.slot] = x.tickets;
          slot_dl[x.slot] = x.deadline;
          if (!ring_live) begin
            ring_head = x.slot;
            ring_live = 1'b1;
          end else begin
            ring_next[ring_tail] = x.slot;
          end
          ring_tail = x.slot;
          ring_next[x.slot] = ring_head;
          r.found = 1'b1;
        end
      end
      lerp_pkg::OP_REMOVE: begin
        if (slot_busy[x.slot]) begin
          ring_unlink(x.slot);
          slot_busy[x.slot] = 1'b0;
          r.found = 1'b1;
        end
      end
      lerp_pkg::OP_READY: begin
        if (slot_busy[x.slot]) begin
          slot_rdy[x.slot] = x.ready_req;
          r.found = 1'b1;
        end
      end
      default: begin
        cur_ok = x.cur_valid && slot_busy[x.cur_slot];
        if (lottery_pick(x.draw, who)) begin
          r = '{1'b1, who, lerp_pkg::CLS_LOTTERY};
        end else if (deadline_pick(who)) begin
          r = '{1'b1, who, lerp_pkg::CLS_REALTIME};
        end else if (rotation_pick(cur_ok, x.cur_slot, who)) begin
          r = '{1'b1, who, lerp_pkg::CLS_RR};
        end
      end
    endcase
    return r;
  endfunction

  function automatic sched_op_t make_op(input logic [1:0] op, input logic [3:0] slot,
                                        input logic [1:0] cls, input logic [7:0] tix,
                                        input logic [30:0] dl, input logic rdy,
                                        input logic cv, input logic [3:0] cs,
                                        input logic [30:0] draw);
    sched_op_t x;
    x = '{op, slot, cls, tix, dl, rdy, cv, cs, draw};
    return x;
  endfunction

  // Random operation: adds and selects dominate so the ring stays populated,
  // deadlines often come from a narrow range so that ties happen.
  function automatic sched_op_t random_op();
    sched_op_t   x;
    int unsigned w;
    w = $urandom_range(99);
    x.op = (w < 30) ? lerp_pkg::OP_ADD : (w < 45) ? lerp_pkg::OP_REMOVE :
           (w < 60) ? lerp_pkg::OP_READY : lerp_pkg::OP_SELECT;
    x.slot = 4'($urandom);
    w = $urandom_range(99);
    x.cls = (w < 5) ? 2'd3 : 2'($urandom_range(2));
    w = $urandom_range(9);
    x.tickets = (w == 0) ? 8'd0 : (w == 1) ? 8'hff : 8'($urandom);
    w = $urandom_range(9);
    x.deadline = (w < 5) ? 31'($urandom_range(7)) : (w == 5) ? '1 : 31'($urandom);
    x.ready_req = ($urandom_range(99) < 60);
    x.cur_valid = ($urandom_range(99) < 75);
    x.cur_slot = 4'($urandom);
    w = $urandom_range(9);
    x.draw = (w == 0) ? '0 : (w == 1) ? '1 : 31'($urandom);
    return x;
  endfunction

  // Driver: a new item may be presented once the previous one is accepted.
  always @(posedge clk) begin
    sched_op_t x;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_decisions.push_back(apply_op(make_op(in_op, in_slot, in_sched_class,
          in_ticket_count, in_deadline, in_ready_req, in_current_valid,
          in_current_slot, in_random_draw)));
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          x = pending_ops.pop_front();
          in_valid         <= 1'b1;
          in_op            <= x.op;
          in_slot          <= x.slot;
          in_sched_class   <= x.cls;
          in_ticket_count  <= x.tickets;
          in_deadline      <= x.deadline;
          in_ready_req     <= x.ready_req;
          in_current_valid <= x.cur_valid;
          in_current_slot  <= x.cur_slot;
          in_random_draw   <= x.draw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is checked against the oldest owed decision.
  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_decisions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0d slot=%0d policy=%0d",
                     out_found, out_chosen_slot, out_chosen_policy);
        end else begin
          want = owed_decisions.pop_front();
          if (out_found !== want.found || out_chosen_slot !== want.slot ||
              out_chosen_policy !== want.policy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found=%0d slot=%0d policy=%0d, got %0d %0d %0d",
                       want.found, want.slot, want.policy,
                       out_found, out_chosen_slot, out_chosen_policy);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which no channel moves anything.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (owed_decisions.size() > 0 || pending_ops.size() > 0 || in_valid ||
                 cfg_valid) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Writes one turn-limit register and mirrors it once the write is taken.
  task automatic write_limit(input logic idx, input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lerp_pkg::CFG_LOT_LIMIT) lot_cap = val;
    else rt_cap = val;
  endtask

  // Waits until every queued item is accepted and answered, then lets the
  // block sit idle before anything else changes.
  task automatic drain();
    do @(negedge clk); while (pending_ops.size() > 0 || in_valid ||
                              owed_decisions.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Turn-limit pairs for each phase; the first phase runs on reset values.
  logic [3:0] lot_set[6] = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd2};
  logic [3:0] rt_set[6]  = '{4'd3, 4'd0, 4'd15, 4'd2, 4'd0, 4'd15};

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = lerp_pkg::OP_ADD;
    in_slot = '0;
    in_sched_class = lerp_pkg::CLS_RR;
    in_ticket_count = '0;
    in_deadline = '0;
    in_ready_req = 1'b0;
    in_current_valid = 1'b0;
    in_current_slot = '0;
    in_random_draw = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lerp_pkg::CFG_LOT_LIMIT;
    cfg_data = '0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    mismatches = 0;
    quiet_cycles = 0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_busy[i] = 1'b0;
      slot_rdy[i] = 1'b0;
      slot_cls[i] = lerp_pkg::CLS_RR;
      slot_tix[i] = '0;
      slot_dl[i] = '0;
      ring_next[i] = '0;
    end
    ring_head = '0;
    ring_tail = '0;
    ring_live = 1'b0;
    lot_run = '0;
    rt_run = '0;
    lot_cap = lerp_pkg::TURN_LIMIT_RST;
    rt_cap = lerp_pkg::TURN_LIMIT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty-ring select, each class, a zero-ticket lottery
    // slot, a class that no policy serves, duplicate adds, operations on
    // unused slots, deadline ties, field extremes and the turn limits.
    @(negedge clk);
    pending_ops.push_back(make_op(lerp_pkg::OP_SELECT, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd0, lerp_pkg::CLS_LOTTERY, 8'hff, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd15, lerp_pkg::CLS_REALTIME, 8'd0, '1,
                                  1'b1, 1'b1, 4'd15, '1));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd1, lerp_pkg::CLS_RR, 8'd7, 31'd5,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd2, 2'd3, 8'd9, 31'd1,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd3, lerp_pkg::CLS_LOTTERY, 8'd0, 31'd2,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd4, lerp_pkg::CLS_REALTIME, 8'd1, '1,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_ADD, 4'd0, lerp_pkg::CLS_RR, 8'd1, 31'd1,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_REMOVE, 4'd5, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_READY, 4'd5, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b1, 1'b0, 4'd0, '0));
    for (int i = 0; i < 4; i++)
      pending_ops.push_back(make_op(lerp_pkg::OP_SELECT, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                    1'b0, 1'b1, 4'(i), (i == 0) ? '0 : '1));
    pending_ops.push_back(make_op(lerp_pkg::OP_READY, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    for (int i = 0; i < 4; i++)
      pending_ops.push_back(make_op(lerp_pkg::OP_SELECT, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                    1'b0, 1'b1,
                                    (i == 0) ? 4'd1 : (i == 1) ? 4'd9 : 4'd15, 31'd77));
    pending_ops.push_back(make_op(lerp_pkg::OP_READY, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b1, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_REMOVE, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_REMOVE, 4'd15, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_REMOVE, 4'd2, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b0, 4'd0, '0));
    pending_ops.push_back(make_op(lerp_pkg::OP_SELECT, 4'd0, lerp_pkg::CLS_RR, 8'd0, '0,
                                  1'b0, 1'b1, 4'd1, '1));

    // Random phases: each runs its own turn limits; idling shifts every two.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_limit(lerp_pkg::CFG_LOT_LIMIT, lot_set[ph]);
        write_limit(lerp_pkg::CFG_RT_LIMIT, rt_set[ph]);
        @(negedge clk);
      end
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 16 : 0;
      for (int n = 0; n < 242; n++) pending_ops.push_back(random_op());
    end
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/lerp_pkg.sv
rtl/core/lerp_ram.sv
rtl/core/lerp_alu.sv
rtl/core/lottery_edf_round_robin_picker.sv
dv/lottery_edf_round_robin_picker_tb.sv
